/* hw/rtl/rsps_pkg.sv */
// ----------------------------------------------------------------------------
// RGB565 shape pixel shader package
// Shared types, constants and helper functions for the pixel shader.
// ----------------------------------------------------------------------------
package rsps_pkg;

	// Visible screen area; pixels outside it are never written.
	localparam int SCREEN_WIDTH  = 1024;
	localparam int SCREEN_HEIGHT = 600;

	// Queue between the front and back parts.
	localparam int MID_DEPTH = 8;
	localparam int MID_AW    = $clog2(MID_DEPTH);
	localparam int MID_CW    = $clog2(MID_DEPTH + 1);

	// Result queue at the output of the back part.
	localparam int OUT_DEPTH = 16;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 24;

	typedef enum logic [CFG_IW-1:0] {
		CFG_MODE     = 3'd0,
		CFG_ORIGIN_X = 3'd1,
		CFG_ORIGIN_Y = 3'd2,
		CFG_EXTENT_W = 3'd3,
		CFG_EXTENT_H = 3'd4,
		CFG_RADIUS   = 3'd5,
		CFG_COLOR    = 3'd6,
		CFG_ALPHA    = 3'd7
	} cfg_reg_t;

	// Drawing modes.
	localparam logic [1:0] MODE_RECT   = 2'd0;
	localparam logic [1:0] MODE_CIRCLE = 2'd1;
	localparam logic [1:0] MODE_GLOW   = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] GLOW_MIN_K   = 8'd7;

	// Serial divider: dividends for the band reciprocal and the glow scale.
	localparam int          DIV_STEPS  = 25;
	localparam int          DIV_CW     = $clog2(DIV_STEPS);
	localparam logic [24:0] RECIP_NUM  = 25'h100_0000;
	localparam logic [24:0] GLOW_NUM   = 25'h001_0000;
	localparam int          RECIP_SHIFT = 24;

	// Configuration sequencer states.
	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SQUARE,
		CS_RECIP,
		CS_INV
	} cfg_state_t;

	// Work classes decided by the front part.
	typedef enum logic [2:0] {
		CLS_SKIP,
		CLS_FILL,
		CLS_BLEND,
		CLS_FADE,
		CLS_GLOW
	} cls_t;

	// Input beat.
	typedef struct packed {
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [15:0] dest_pixel;
	} pixel_t;

	// Result beat.
	typedef struct packed {
		logic [15:0] new_pixel;
		logic        write_enable;
	} shade_t;

	// Classified pixel handed from the front to the back part.
	typedef struct packed {
		cls_t        cls;
		logic [15:0] dest;
		logic [16:0] slack;
	} job_t;

	// Configuration registers and the values derived from them.
	typedef struct packed {
		logic [1:0]  mode;
		logic [12:0] origin_x;
		logic [12:0] origin_y;
		logic [11:0] extent_w;
		logic [11:0] extent_h;
		logic [10:0] radius;
		logic [23:0] color;
		logic [7:0]  alpha;
		logic [21:0] r2;
		logic [11:0] band;
		logic [24:0] band_recip;
		logic [16:0] glow_inv;
	} cfg_t;

	// Pack 8-bit channels into RGB565 by truncation.
	function automatic logic [15:0] pack_rgb(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

/* hw/rtl/rgb565_shape_pixel_shader.sv */
// Throughput: one pixel per clock while full is low; full rises while the
// configuration is busy or the credit loops around the two queues run out.
// A write to the radius register keeps full high and cfg_ready low while
// the serial divider derives the fade reciprocal and the glow scale, one bit a cycle.
// Reset clears the configuration and valid registers, fills both credit counters,
// empties both queues and leaves the block ready at once.
// ----------------------------------------------------------------------------
// RGB565 shape pixel shader
// Shades framebuffer pixels for an alpha rectangle, a soft circle or an
// additive glow, one pixel per clock while full is low.
// ----------------------------------------------------------------------------
module rgb565_shape_pixel_shader (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  rsps_pkg::pixel_t            pixel,
	input  logic                        pop,
	output logic                        empty,
	output rsps_pkg::shade_t            shade,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rsps_pkg::CFG_IW-1:0] cfg_index,
	input  logic [rsps_pkg::CFG_DW-1:0] cfg_data
);

	rsps_pkg::cfg_t cfg;
	rsps_pkg::job_t job, mid_head;
	logic           busy;
	logic           job_valid;
	logic           mid_empty;
	logic           mid_pop;

	// Configuration registers and derived values.
	rsps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.busy      (busy)
	);

	// Coverage tests and classification.
	rsps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.busy      (busy),
		.cfg       (cfg),
		.mid_pop   (mid_pop),
		.job_valid (job_valid),
		.job       (job)
	);

	// Decoupling queue.
	rsps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (job_valid),
		.wr_job   (job),
		.rd_pop   (mid_pop),
		.empty    (mid_empty),
		.head     (mid_head)
	);

	// Weighting, blending and result queue.
	rsps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_head  (mid_head),
		.mid_pop   (mid_pop),
		.cfg       (cfg),
		.pop       (pop),
		.empty     (empty),
		.shade     (shade)
	);

endmodule

/* hw/rtl/rsps_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the shader registers and derives the squared radius, the fade band,
// its reciprocal and the glow scale with a shared serial divider.
// ----------------------------------------------------------------------------
module rsps_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [rsps_pkg::CFG_IW-1:0] cfg_index,
	input  logic [rsps_pkg::CFG_DW-1:0] cfg_data,
	output rsps_pkg::cfg_t              cfg,
	output logic                        busy
);

	rsps_pkg::cfg_state_t state_q, state_nx;

	logic        wr;
	logic        div_run;
	logic        last;
	logic [1:0]  mode_q;
	logic [12:0] origin_x_q, origin_y_q;
	logic [11:0] extent_w_q, extent_h_q;
	logic [10:0] radius_q;
	logic [23:0] color_q;
	logic [7:0]  alpha_q;
	logic [21:0] r2_q;
	logic [11:0] band_q;
	logic [24:0] recip_q;
	logic [16:0] inv_q;
	logic [11:0] band_nx;

	logic [rsps_pkg::DIV_CW-1:0] cnt_q;
	logic [24:0] num_q, quo_q, quo_nx;
	logic [21:0] div_d_q, rem_q, rem_nx;
	logic [22:0] rem_sh;
	logic        ge;

	assign wr      = cfg_valid && cfg_ready;
	assign band_nx = {radius_q, 1'b0} - 12'd1;
	assign last    = (cnt_q == rsps_pkg::DIV_CW'(rsps_pkg::DIV_STEPS - 1));

	// One restoring division step per cycle.
	always_comb begin
		rem_sh = {rem_q, num_q[24]};
		ge     = (rem_sh >= {1'b0, div_d_q});
		rem_nx = ge ? 22'(rem_sh - {1'b0, div_d_q}) : rem_sh[21:0];
		quo_nx = {quo_q[23:0], ge};
	end

	// Sequencer next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rsps_pkg::CS_IDLE: begin
				if (wr && cfg_index == rsps_pkg::CFG_RADIUS)
					state_nx = rsps_pkg::CS_SQUARE;
			end
			rsps_pkg::CS_SQUARE: state_nx = rsps_pkg::CS_RECIP;
			rsps_pkg::CS_RECIP: begin
				if (last)
					state_nx = rsps_pkg::CS_INV;
			end
			rsps_pkg::CS_INV: begin
				if (last)
					state_nx = rsps_pkg::CS_IDLE;
			end
			default: state_nx = rsps_pkg::CS_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy    = 1'b1;
		div_run = 1'b0;
		case (state_q)
			rsps_pkg::CS_IDLE:   busy = 1'b0;
			rsps_pkg::CS_SQUARE: div_run = 1'b0;
			rsps_pkg::CS_RECIP:  div_run = 1'b1;
			rsps_pkg::CS_INV:    div_run = 1'b1;
			default:             busy = 1'b1;
		endcase
	end

	assign cfg_ready = !busy;

	// Control state, registers and derived values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rsps_pkg::CS_IDLE;
			cnt_q      <= '0;
			mode_q     <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			extent_w_q <= '0;
			extent_h_q <= '0;
			radius_q   <= '0;
			color_q    <= '0;
			alpha_q    <= '0;
			r2_q       <= '0;
			band_q     <= '0;
			recip_q    <= '0;
			inv_q      <= '0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= (div_run && !last) ? cnt_q + 1'b1 : '0;
			if (wr) begin
				case (cfg_index)
					rsps_pkg::CFG_MODE:     mode_q     <= cfg_data[1:0];
					rsps_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data[12:0];
					rsps_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data[12:0];
					rsps_pkg::CFG_EXTENT_W: extent_w_q <= cfg_data[11:0];
					rsps_pkg::CFG_EXTENT_H: extent_h_q <= cfg_data[11:0];
					rsps_pkg::CFG_RADIUS:   radius_q   <= cfg_data[10:0];
					rsps_pkg::CFG_COLOR:    color_q    <= cfg_data[23:0];
					rsps_pkg::CFG_ALPHA:    alpha_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (state_q == rsps_pkg::CS_SQUARE) begin
				r2_q   <= {11'b0, radius_q} * {11'b0, radius_q};
				band_q <= band_nx;
			end
			if (state_q == rsps_pkg::CS_RECIP && last)
				recip_q <= quo_nx;
			if (state_q == rsps_pkg::CS_INV && last)
				inv_q <= quo_nx[16:0];
		end
	end

	// Divider datapath: reciprocal of the band first, then the glow scale.
	always_ff @(posedge clk) begin
		if (state_q == rsps_pkg::CS_SQUARE) begin
			num_q   <= rsps_pkg::RECIP_NUM;
			div_d_q <= {10'b0, band_nx};
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (div_run) begin
			if (state_q == rsps_pkg::CS_RECIP && last) begin
				num_q   <= rsps_pkg::GLOW_NUM;
				div_d_q <= r2_q;
				rem_q   <= '0;
				quo_q   <= '0;
			end else begin
				num_q <= {num_q[23:0], 1'b0};
				rem_q <= rem_nx;
				quo_q <= quo_nx;
			end
		end
	end

	assign cfg.mode       = mode_q;
	assign cfg.origin_x   = origin_x_q;
	assign cfg.origin_y   = origin_y_q;
	assign cfg.extent_w   = extent_w_q;
	assign cfg.extent_h   = extent_h_q;
	assign cfg.radius     = radius_q;
	assign cfg.color      = color_q;
	assign cfg.alpha      = alpha_q;
	assign cfg.r2         = r2_q;
	assign cfg.band       = band_q;
	assign cfg.band_recip = recip_q;
	assign cfg.glow_inv   = inv_q;

endmodule

/* hw/rtl/rsps_front.sv */
// ----------------------------------------------------------------------------
// Front part
// Accepts pixels, tests coverage of the rectangle or circle and classifies
// each pixel into the work that the back part has to do.
// ----------------------------------------------------------------------------
module rsps_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  rsps_pkg::pixel_t pixel,
	input  logic             busy,
	input  rsps_pkg::cfg_t   cfg,
	input  logic             mid_pop,
	output logic             job_valid,
	output rsps_pkg::job_t   job
);

	logic [rsps_pkg::MID_CW-1:0] cred_q;
	logic                        accept;

	logic        valid_s1, valid_s2, valid_s3;
	logic [9:0]  px_s1, py_s1;
	logic [15:0] dest_s1, dest_s2, dest_s3;
	logic        onscreen_s2, onscreen_s3, rect_s2, rect_s3;
	logic signed [13:0] dx_s2, dy_s2;
	logic [24:0] dx2_s3, dy2_s3;

	logic        onscreen, rect_hit;
	logic signed [13:0] px14, py14, ox14, oy14, x_end, y_end, dx, dy;
	logic signed [27:0] dxx, dyy;
	logic [25:0] d2;
	logic [21:0] slack;
	logic        in_disc, fade, round_ok;

	// Credits cover every beat in flight or waiting in the queue.
	assign full   = busy || (cred_q == '0);
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q   <= rsps_pkg::MID_CW'(rsps_pkg::MID_DEPTH);
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			cred_q   <= cred_q + rsps_pkg::MID_CW'(mid_pop) - rsps_pkg::MID_CW'(accept);
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: screen and rectangle tests, offsets from the origin.
	always_comb begin
		onscreen = ({3'b0, px_s1} < 13'(rsps_pkg::SCREEN_WIDTH)) &&
			({3'b0, py_s1} < 13'(rsps_pkg::SCREEN_HEIGHT));
		px14  = $signed({4'b0, px_s1});
		py14  = $signed({4'b0, py_s1});
		ox14  = $signed({cfg.origin_x[12], cfg.origin_x});
		oy14  = $signed({cfg.origin_y[12], cfg.origin_y});
		x_end = ox14 + $signed({2'b0, cfg.extent_w});
		y_end = oy14 + $signed({2'b0, cfg.extent_h});
		rect_hit = (px14 >= ox14) && (px14 < x_end) && (py14 >= oy14) && (py14 < y_end);
		dx = px14 - ox14;
		dy = py14 - oy14;
	end

	// Stage 2: squares of the offsets.
	always_comb begin
		dxx = dx_s2 * dx_s2;
		dyy = dy_s2 * dy_s2;
	end

	// Stage 3: distance against the radius, then classification.
	always_comb begin
		d2       = {1'b0, dx2_s3} + {1'b0, dy2_s3};
		in_disc  = ({4'b0, cfg.r2} >= d2);
		slack    = cfg.r2 - d2[21:0];
		fade     = (slack < {10'b0, cfg.band});
		round_ok = (cfg.radius != '0);
		job.cls  = rsps_pkg::CLS_SKIP;
		case (cfg.mode)
			rsps_pkg::MODE_RECT: begin
				if (rect_s3 && cfg.alpha != '0)
					job.cls = (cfg.alpha == rsps_pkg::ALPHA_OPAQUE) ?
						rsps_pkg::CLS_FILL : rsps_pkg::CLS_BLEND;
			end
			rsps_pkg::MODE_CIRCLE: begin
				if (round_ok && in_disc) begin
					if (fade)
						job.cls = rsps_pkg::CLS_FADE;
					else if (cfg.alpha != '0)
						job.cls = rsps_pkg::CLS_BLEND;
				end
			end
			rsps_pkg::MODE_GLOW: begin
				if (round_ok && in_disc && slack != '0 && cfg.glow_inv != '0)
					job.cls = rsps_pkg::CLS_GLOW;
			end
			default: job.cls = rsps_pkg::CLS_SKIP;
		endcase
		if (!onscreen_s3)
			job.cls = rsps_pkg::CLS_SKIP;
		job.dest  = dest_s3;
		job.slack = slack[16:0];
	end

	assign job_valid = valid_s3;

	// Pipeline payload.
	always_ff @(posedge clk) begin
		px_s1       <= pixel.pixel_x;
		py_s1       <= pixel.pixel_y;
		dest_s1     <= pixel.dest_pixel;
		dest_s2     <= dest_s1;
		onscreen_s2 <= onscreen;
		rect_s2     <= rect_hit;
		dx_s2       <= dx;
		dy_s2       <= dy;
		dest_s3     <= dest_s2;
		onscreen_s3 <= onscreen_s2;
		rect_s3     <= rect_s2;
		dx2_s3      <= dxx[24:0];
		dy2_s3      <= dyy[24:0];
	end

endmodule

/* hw/rtl/rsps_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Short queue of classified pixels between the front and back parts.
// ----------------------------------------------------------------------------
module rsps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  rsps_pkg::job_t wr_job,
	input  logic           rd_pop,
	output logic           empty,
	output rsps_pkg::job_t head
);

	rsps_pkg::job_t mem_q [rsps_pkg::MID_DEPTH];

	logic [rsps_pkg::MID_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [rsps_pkg::MID_CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_valid)
				wr_ptr_q <= (wr_ptr_q == rsps_pkg::MID_AW'(rsps_pkg::MID_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (rd_pop)
				rd_ptr_q <= (rd_ptr_q == rsps_pkg::MID_AW'(rsps_pkg::MID_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + rsps_pkg::MID_CW'(wr_valid) - rsps_pkg::MID_CW'(rd_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_valid)
			mem_q[wr_ptr_q] <= wr_job;
	end

endmodule

/* hw/rtl/rsps_back.sv */
// ----------------------------------------------------------------------------
// Back part
// Works out the blend weight or glow intensity of each classified pixel,
// blends or adds the colour and queues the result beats.
// ----------------------------------------------------------------------------
module rsps_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             mid_empty,
	input  rsps_pkg::job_t   mid_head,
	output logic             mid_pop,
	input  rsps_pkg::cfg_t   cfg,
	input  logic             pop,
	output logic             empty,
	output rsps_pkg::shade_t shade
);

	logic [rsps_pkg::OUT_CW-1:0] cred_q, cnt_q;
	logic [rsps_pkg::OUT_AW-1:0] wr_ptr_q, rd_ptr_q;
	rsps_pkg::shade_t            out_q [rsps_pkg::OUT_DEPTH];
	rsps_pkg::shade_t            result;
	logic                        out_pop;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	rsps_pkg::cls_t cls_s1, cls_s2, cls_s3, cls_s4, cls_s5, cls_s6;
	logic [15:0] dest_s1, dest_s2, dest_s3, dest_s4, dest_s5, dest_s6;
	logic [16:0] slack_s1;
	logic [33:0] p1_s2;
	logic [19:0] n_s3, n_s4;
	logic [44:0] p2_s3;
	logic [7:0]  q0_s4, k_s4;
	logic [19:0] qb_s4;
	logic [7:0]  w_s5;
	logic        en_s5, en_s6;
	logic [15:0] ps_r_s6, ps_g_s6, ps_b_s6, pd_r_s6, pd_g_s6, pd_b_s6;

	logic [16:0] m1_a, m1_b;
	logic [33:0] p1;
	logic [7:0]  t;
	logic [19:0] m2_a;
	logic [24:0] m2_b;
	logic [44:0] p2;
	logic [7:0]  q0;
	logic [19:0] qb;
	logic [19:0] rem;
	logic [7:0]  a_fade, w;
	logic        en;
	logic [7:0]  dr, dg, db, winv;
	logic [15:0] ps_r, ps_g, ps_b, pd_r, pd_g, pd_b;
	logic [16:0] sum_r, sum_g, sum_b;
	logic [8:0]  gl_r, gl_g, gl_b;
	logic [7:0]  sat_r, sat_g, sat_b;

	// Take a job only while the result queue has room for it.
	assign mid_pop = !mid_empty && (cred_q != '0);
	assign out_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q   <= rsps_pkg::OUT_CW'(rsps_pkg::OUT_DEPTH);
			cnt_q    <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			cred_q   <= cred_q + rsps_pkg::OUT_CW'(out_pop) - rsps_pkg::OUT_CW'(mid_pop);
			cnt_q    <= cnt_q + rsps_pkg::OUT_CW'(valid_s6) - rsps_pkg::OUT_CW'(out_pop);
			if (valid_s6)
				wr_ptr_q <= (wr_ptr_q == rsps_pkg::OUT_AW'(rsps_pkg::OUT_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (out_pop)
				rd_ptr_q <= (rd_ptr_q == rsps_pkg::OUT_AW'(rsps_pkg::OUT_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			valid_s1 <= mid_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Stage 1: alpha times slack for a fade, slack times scale for a glow.
	always_comb begin
		if (cls_s1 == rsps_pkg::CLS_FADE) begin
			m1_a = {9'b0, cfg.alpha};
			m1_b = slack_s1;
		end else begin
			m1_a = slack_s1;
			m1_b = cfg.glow_inv;
		end
		p1 = {17'b0, m1_a} * {17'b0, m1_b};
	end

	// Stage 2: reciprocal multiply for a fade, clamped square for a glow.
	always_comb begin
		t = (p1_s2[33:8] > 26'd255) ? 8'hFF : p1_s2[15:8];
		if (cls_s2 == rsps_pkg::CLS_FADE) begin
			m2_a = p1_s2[19:0];
			m2_b = cfg.band_recip;
		end else begin
			m2_a = {12'b0, t};
			m2_b = {17'b0, t};
		end
		p2 = {25'b0, m2_a} * {20'b0, m2_b};
	end

	// Stage 3: trial quotient times band for the correction step.
	always_comb begin
		q0 = p2_s3[rsps_pkg::RECIP_SHIFT +: 8];
		qb = {12'b0, q0} * {8'b0, cfg.band};
	end

	// Stage 4: corrected fade alpha, weight and write decision.
	always_comb begin
		rem    = n_s4 - qb_s4;
		a_fade = q0_s4 + 8'((rem >= {8'b0, cfg.band}) ? 1 : 0);
		w      = cfg.alpha;
		en     = 1'b0;
		case (cls_s4)
			rsps_pkg::CLS_FILL:  en = 1'b1;
			rsps_pkg::CLS_BLEND: en = 1'b1;
			rsps_pkg::CLS_FADE: begin
				w  = a_fade;
				en = (a_fade != '0);
			end
			rsps_pkg::CLS_GLOW: begin
				w  = k_s4;
				en = (k_s4 > rsps_pkg::GLOW_MIN_K);
			end
			default: en = 1'b0;
		endcase
	end

	// Stage 5: channel products against the weight and its complement.
	always_comb begin
		dr   = {dest_s5[15:11], dest_s5[15:13]};
		dg   = {dest_s5[10:5], dest_s5[10:9]};
		db   = {dest_s5[4:0], dest_s5[4:2]};
		winv = rsps_pkg::ALPHA_OPAQUE - w_s5;
		ps_r = {8'b0, cfg.color[23:16]} * {8'b0, w_s5};
		ps_g = {8'b0, cfg.color[15:8]} * {8'b0, w_s5};
		ps_b = {8'b0, cfg.color[7:0]} * {8'b0, w_s5};
		pd_r = {8'b0, dr} * {8'b0, winv};
		pd_g = {8'b0, dg} * {8'b0, winv};
		pd_b = {8'b0, db} * {8'b0, winv};
	end

	// Stage 6: blend sums, saturating glow and packing.
	always_comb begin
		sum_r = {1'b0, ps_r_s6} + {1'b0, pd_r_s6};
		sum_g = {1'b0, ps_g_s6} + {1'b0, pd_g_s6};
		sum_b = {1'b0, ps_b_s6} + {1'b0, pd_b_s6};
		gl_r  = {1'b0, dest_s6[15:11], 3'b0} + {1'b0, ps_r_s6[15:8]};
		gl_g  = {1'b0, dest_s6[10:5], 2'b0} + {1'b0, ps_g_s6[15:8]};
		gl_b  = {1'b0, dest_s6[4:0], 3'b0} + {1'b0, ps_b_s6[15:8]};
		sat_r = gl_r[8] ? 8'hFF : gl_r[7:0];
		sat_g = gl_g[8] ? 8'hFF : gl_g[7:0];
		sat_b = gl_b[8] ? 8'hFF : gl_b[7:0];
		result.new_pixel    = dest_s6;
		result.write_enable = en_s6;
		if (en_s6) begin
			case (cls_s6)
				rsps_pkg::CLS_FILL:
					result.new_pixel = rsps_pkg::pack_rgb(cfg.color[23:16],
						cfg.color[15:8], cfg.color[7:0]);
				rsps_pkg::CLS_BLEND, rsps_pkg::CLS_FADE:
					result.new_pixel = rsps_pkg::pack_rgb(sum_r[15:8], sum_g[15:8],
						sum_b[15:8]);
				rsps_pkg::CLS_GLOW:
					result.new_pixel = rsps_pkg::pack_rgb(sat_r, sat_g, sat_b);
				default: result.new_pixel = dest_s6;
			endcase
		end
	end

	// Pipeline payload and result storage.
	always_ff @(posedge clk) begin
		cls_s1   <= mid_head.cls;
		dest_s1  <= mid_head.dest;
		slack_s1 <= mid_head.slack;
		cls_s2   <= cls_s1;
		dest_s2  <= dest_s1;
		p1_s2    <= p1;
		cls_s3   <= cls_s2;
		dest_s3  <= dest_s2;
		n_s3     <= p1_s2[19:0];
		p2_s3    <= p2;
		cls_s4   <= cls_s3;
		dest_s4  <= dest_s3;
		n_s4     <= n_s3;
		q0_s4    <= q0;
		qb_s4    <= qb;
		k_s4     <= p2_s3[15:8];
		cls_s5   <= cls_s4;
		dest_s5  <= dest_s4;
		w_s5     <= w;
		en_s5    <= en;
		cls_s6   <= cls_s5;
		dest_s6  <= dest_s5;
		en_s6    <= en_s5;
		ps_r_s6  <= ps_r;
		ps_g_s6  <= ps_g;
		ps_b_s6  <= ps_b;
		pd_r_s6  <= pd_r;
		pd_g_s6  <= pd_g;
		pd_b_s6  <= pd_b;
		if (valid_s6)
			out_q[wr_ptr_q] <= result;
	end

	assign empty = (cnt_q == '0);
	assign shade = out_q[rd_ptr_q];

endmodule

/* tb/sv/tb_rgb565_shape_pixel_shader.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB565 shape pixel shader testbench
// Drives pixel beats from a backlog queue and predicts every shaded result
// from a behavioural copy of the rectangle, soft circle and glow arithmetic.
// Each popped result is checked field by field against the oldest
// prediction. The run is a short directed part followed by randomised
// phases, each with its own register setting, while both sides idle and stall.
// ----------------------------------------------------------------------------
module tb_rgb565_shape_pixel_shader;
	import rsps_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         TAIL_CYCLES = 20;
	localparam int         IDLE_LIMIT  = 5000;
	localparam int         RAND_ITEMS  = 2000;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                push      = 1'b0;
	logic                full;
	pixel_t              pixel     = '0;
	logic                pop       = 1'b0;
	logic                empty;
	shade_t              shade;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_IW-1:0]   cfg_index = CFG_MODE;
	logic [CFG_DW-1:0]   cfg_data  = '0;

	// Shadow copy of the configuration registers.
	logic [1:0]          sh_mode   = MODE_RECT;
	logic signed [12:0]  sh_ox     = '0;
	logic signed [12:0]  sh_oy     = '0;
	logic [11:0]         sh_w      = '0;
	logic [11:0]         sh_h      = '0;
	logic [10:0]         sh_rad    = '0;
	logic [23:0]         sh_color  = '0;
	logic [7:0]          sh_alpha  = '0;

	pixel_t              pixel_backlog[$];
	shade_t              due_shades[$];
	shade_t              want;
	int                  err_cnt     = 0;
	int                  idle_cycles = 0;

	int                  burst_left  = 1;
	int                  gap_left    = 0;
	int                  hold_left   = 0;
	bit                  held_once   = 1'b0;
	int                  style       = 0;
	int                  style_left  = 0;
	int                  rx_tick     = 0;

	rgb565_shape_pixel_shader uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pixel     (pixel),
		.pop       (pop),
		.empty     (empty),
		.shade     (shade),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Free-running clock, 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Alpha blend of the source colour over an RGB565 value widened by bit
	// replication.
	function automatic logic [15:0] mix(logic [15:0] d, int a);
		int dr, dg, db, sr, sg, sb, na, r, g, b;
		dr = {d[15:11], d[15:13]};
		dg = {d[10:5], d[10:9]};
		db = {d[4:0], d[4:2]};
		sr = sh_color[23:16];
		sg = sh_color[15:8];
		sb = sh_color[7:0];
		na = 255 - a;
		r  = (sr * a + dr * na) >> 8;
		g  = (sg * a + dg * na) >> 8;
		b  = (sb * a + db * na) >> 8;
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// Additive glow on one channel, saturating at full scale.
	function automatic int lift(int d, int c, int k);
		int v;
		v = d + ((c * k) >> 8);
		return (v > 255) ? 255 : v;
	endfunction

	// Expected shaded result of one pixel under the current registers.
	function automatic shade_t shade_of(pixel_t p);
		longint px, py, ox, oy, dx, dy, d2, r2, band, a, inv, slack, t, k;
		int     r, g, b;
		shade_t s;
		px = p.pixel_x;
		py = p.pixel_y;
		ox = longint'(sh_ox);
		oy = longint'(sh_oy);
		s.new_pixel    = p.dest_pixel;
		s.write_enable = 1'b0;
		if (px < SCREEN_WIDTH && py < SCREEN_HEIGHT) begin
			if (sh_mode == MODE_RECT) begin
				if (sh_alpha != 8'd0 && px >= ox && px < ox + longint'(sh_w) &&
						py >= oy && py < oy + longint'(sh_h)) begin
					if (sh_alpha == ALPHA_OPAQUE)
						s.new_pixel = {sh_color[23:19], sh_color[15:10], sh_color[7:3]};
					else
						s.new_pixel = mix(p.dest_pixel, int'(sh_alpha));
					s.write_enable = 1'b1;
				end
			end else if ((sh_mode == MODE_CIRCLE || sh_mode == MODE_GLOW) &&
					sh_rad != 11'd0) begin
				dx = px - ox;
				dy = py - oy;
				d2 = dx * dx + dy * dy;
				r2 = longint'(sh_rad) * longint'(sh_rad);
				if (d2 <= r2) begin
					if (sh_mode == MODE_CIRCLE) begin
						// Alpha fades to nothing across the outer band of the disc.
						band = 2 * longint'(sh_rad) - 1;
						a    = longint'(sh_alpha);
						if (d2 > r2 - band)
							a = (longint'(sh_alpha) * (r2 - d2)) / band;
						if (a > 0) begin
							s.new_pixel    = mix(p.dest_pixel, int'(a));
							s.write_enable = 1'b1;
						end
					end else begin
						// Quadratic falloff; weak intensities leave the pixel alone.
						inv   = 65536 / r2;
						slack = r2 - d2;
						if (slack > 0) begin
							t = (slack * inv) >> 8;
							if (t > 255)
								t = 255;
							k = (t * t) >> 8;
							if (k > 7) begin
								r = lift({p.dest_pixel[15:11], 3'b000}, sh_color[23:16], int'(k));
								g = lift({p.dest_pixel[10:5], 2'b00}, sh_color[15:8], int'(k));
								b = lift({p.dest_pixel[4:0], 3'b000}, sh_color[7:0], int'(k));
								s.new_pixel    = {r[7:3], g[7:2], b[7:3]};
								s.write_enable = 1'b1;
							end
						end
					end
				end
			end
		end
		return s;
	endfunction

	// Prints a mismatch line for the first 40 mismatches and counts every one.
	task automatic report(string msg);
		if (err_cnt < 40)
			$display("[%0t] mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (gap_left != 0) begin
			gap_left <= gap_left - 1;
			push     <= 1'b0;
		end else if (pixel_backlog.size() != 0) begin
			push  <= 1'b1;
			pixel <= pixel_backlog[0];
			if (burst_left <= 1) begin
				burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
					: $urandom_range(1, 16);
				gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: switches between stall styles at random, holds off at random,
	// and once holds off long enough for the block to fill and stall its input.
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pop       <= 1'b0;
		end else if (!held_once && pixel_backlog.size() > 150) begin
			held_once <= 1'b1;
			hold_left <= 300;
			pop       <= 1'b0;
		end else if ($urandom_range(0, 1999) == 0) begin
			hold_left <= $urandom_range(40, 120);
			pop       <= 1'b0;
		end else begin
			if (style_left == 0) begin
				style      <= $urandom_range(0, 2);
				style_left <= $urandom_range(16, 96);
			end else begin
				style_left <= style_left - 1;
			end
			case (style)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 9) >= 3);
				default: pop <= (rx_tick % 3 != 0);
			endcase
		end
	end

	// Monitor: predicts each accepted pixel, checks each popped result and
	// watches for a stalled run.
	always @(posedge clk) begin
		if (push && !full) begin
			due_shades.push_back(shade_of(pixel));
			void'(pixel_backlog.pop_front());
		end
		if (pop && !empty) begin
			if (due_shades.size() == 0) begin
				report($sformatf("result %h/%b with nothing due", shade.new_pixel,
					shade.write_enable));
			end else begin
				want = due_shades.pop_front();
				if (shade.new_pixel !== want.new_pixel)
					report($sformatf("new_pixel got %h want %h", shade.new_pixel,
						want.new_pixel));
				if (shade.write_enable !== want.write_enable)
					report($sformatf("write_enable got %b want %b (new_pixel %h)",
						shade.write_enable, want.write_enable, want.new_pixel));
			end
		end
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Writes one register and mirrors it in the shadow copy.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_MODE:     sh_mode  = val[1:0];
			CFG_ORIGIN_X: sh_ox    = val[12:0];
			CFG_ORIGIN_Y: sh_oy    = val[12:0];
			CFG_EXTENT_W: sh_w     = val[11:0];
			CFG_EXTENT_H: sh_h     = val[11:0];
			CFG_RADIUS:   sh_rad   = val[10:0];
			CFG_COLOR:    sh_color = val[23:0];
			CFG_ALPHA:    sh_alpha = val[7:0];
			default: ;
		endcase
	endtask

	// Programs a whole shape.
	task automatic setup(logic [1:0] m, int ox, int oy, int w, int h, int rad, int color,
			int a);
		write_reg(CFG_MODE, {22'd0, m});
		write_reg(CFG_ORIGIN_X, {11'd0, 13'(ox)});
		write_reg(CFG_ORIGIN_Y, {11'd0, 13'(oy)});
		write_reg(CFG_EXTENT_W, {12'd0, 12'(w)});
		write_reg(CFG_EXTENT_H, {12'd0, 12'(h)});
		write_reg(CFG_RADIUS, {13'd0, 11'(rad)});
		write_reg(CFG_COLOR, 24'(color));
		write_reg(CFG_ALPHA, {16'd0, 8'(a)});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic offer(int x, int y, int d);
		pixel_t p;
		p.pixel_x    = 10'(x);
		p.pixel_y    = 10'(y);
		p.dest_pixel = 16'(d);
		pixel_backlog.push_back(p);
	endtask

	// Waits until every beat has gone through and the pipeline has drained.
	task automatic settle();
		while (pixel_backlog.size() != 0 || due_shades.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	// Coordinate near a centre, falling back to anywhere on the axis.
	function automatic int near(int c, int span, int hi);
		int v;
		v = c - span + $urandom_range(0, 2 * span);
		if (v < 0 || v > hi)
			v = $urandom_range(0, hi);
		return v;
	endfunction

	// Stimulus: directed corners first, then randomised phases.
	initial begin
		int         sent, ph, n, ox, oy, w, h, rad, color, a, r, x, y;
		logic [1:0] m;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Opaque full-screen fill, screen corners and rows below the screen.
		setup(MODE_RECT, 0, 0, 4095, 4095, 5, 24'hFFFFFF, 255);
		offer(0, 0, 16'h0000);
		offer(1023, 599, 16'hFFFF);
		offer(1023, 1023, 16'hFFFF);
		offer(512, 600, 16'h0000);
		settle();

		// One-pixel rectangle blended at half alpha, with its neighbours.
		setup(MODE_RECT, 10, 20, 1, 1, 0, 24'h123456, 128);
		offer(10, 20, 16'hFFFF);
		offer(11, 20, 16'h1234);
		offer(10, 21, 16'h1234);
		offer(9, 20, 16'h1234);
		settle();

		// Zero width, then zero alpha.
		setup(MODE_RECT, 10, 20, 0, 5, 0, 24'hABCDEF, 200);
		offer(10, 20, 16'h5555);
		settle();
		setup(MODE_RECT, 0, 0, 100, 100, 0, 24'hABCDEF, 0);
		offer(10, 20, 16'hAAAA);
		settle();

		// Soft circle: centre, rim, fade band and just outside.
		setup(MODE_CIRCLE, 100, 100, 0, 0, 10, 24'hFF8000, 255);
		offer(100, 100, 16'h0000);
		offer(110, 100, 16'h0000);
		offer(108, 105, 16'hF0F0);
		offer(111, 100, 16'h0000);
		settle();

		// Circle of zero radius.
		setup(MODE_CIRCLE, 100, 100, 0, 0, 0, 24'hFF8000, 255);
		offer(100, 100, 16'h0000);
		settle();

		// Largest working glow, saturating at the centre, then a radius too big.
		setup(MODE_GLOW, 500, 300, 0, 0, 256, 24'hFFFFFF, 0);
		offer(500, 300, 16'hFFFF);
		offer(700, 300, 16'h1234);
		settle();
		setup(MODE_GLOW, 500, 300, 0, 0, 257, 24'hFFFFFF, 0);
		offer(500, 300, 16'h0000);
		settle();

		// The unused mode with a covering rectangle.
		setup(MODE_UNUSED, 0, 0, 4095, 4095, 100, 24'hFFFFFF, 255);
		offer(50, 50, 16'h0000);
		settle();

		// Register extremes: origins at both ends of their range.
		setup(MODE_RECT, -4096, 4095, 4095, 4095, 2047, 24'h000000, 1);
		offer(0, 0, 16'hFFFF);
		offer(1023, 599, 16'h0001);
		settle();

		// Random phases, each with a fresh shape.
		sent = 0;
		ph   = 0;
		while (sent < RAND_ITEMS) begin
			n = (ph == 0) ? 250 : $urandom_range(30, 160);
			r = $urandom_range(0, 19);
			m = (r == 0) ? MODE_UNUSED : 2'(r % 3);
			ox = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8191)) - 4096
				: int'($urandom_range(0, 1150)) - 64;
			oy = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8191)) - 4096
				: int'($urandom_range(0, 660)) - 64;
			w = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 4095 : 0)
				: $urandom_range(1, 400);
			h = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 4095 : 0)
				: $urandom_range(1, 400);
			case ($urandom_range(0, 19))
				0: rad = 0;
				1: rad = 2047;
				2: rad = 256;
				3: rad = 257;
				default: rad = $urandom_range(1, 300);
			endcase
			color = $urandom_range(0, 24'hFFFFFF);
			case ($urandom_range(0, 11))
				0: a = 0;
				1: a = 255;
				2: a = 1;
				3: a = 254;
				default: a = $urandom_range(0, 255);
			endcase
			settle();
			setup(m, ox, oy, w, h, rad, color, a);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0) begin
					x = $urandom_range(0, 1023);
					y = $urandom_range(0, 1023);
				end else if (m == MODE_RECT) begin
					x = near(ox + w / 2, w / 2 + 4, 1023);
					y = near(oy + h / 2, h / 2 + 4, 599);
				end else begin
					x = near(ox, rad + 4, 1023);
					y = near(oy, rad + 4, 599);
				end
				offer(x, y, $urandom_range(0, 16'hFFFF));
			end
			sent += n;
			ph++;
		end

		// Drain and conclude.
		while (pixel_backlog.size() != 0 || due_shades.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (due_shades.size() != 0)
			report($sformatf("%0d results never arrived", due_shades.size()));
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* rgb565_shape_pixel_shader.f */
hw/rtl/rsps_pkg.sv
hw/rtl/rsps_cfg.sv
hw/rtl/rsps_front.sv
hw/rtl/rsps_queue.sv
hw/rtl/rsps_back.sv
hw/rtl/rgb565_shape_pixel_shader.sv
tb/sv/tb_rgb565_shape_pixel_shader.sv
